FILE: rtl/sfc_pkg.sv
// sfc_pkg: shared types and constants for the sphere/frustum cull pipeline.
// No dependencies; imported by every rtl/sfc_* module and the top level.
package sfc_pkg;

  localparam int PlaneCount  = 6;
  localparam int PosW        = 24;
  localparam int NormW       = 14;
  localparam int DistW       = 22;
  localparam int RadW        = 16;
  localparam int IdxW        = 16;
  localparam int HandleW     = 17;
  localparam int ProdW       = NormW + PosW;   // one normal * position product
  localparam int SumW        = 42;             // exact Q.20 sum, ample headroom
  localparam int FracShift   = 12;             // aligns Q.8 terms to Q.20

  localparam logic [HandleW-1:0] NodeCountMax = 17'd65536;

  // configuration register indexes
  localparam logic [2:0] RegPlaneLeft   = 3'd0;
  localparam logic [2:0] RegPlaneRight  = 3'd1;
  localparam logic [2:0] RegPlaneBottom = 3'd2;
  localparam logic [2:0] RegPlaneTop    = 3'd3;
  localparam logic [2:0] RegPlaneNear   = 3'd4;
  localparam logic [2:0] RegPlaneFar    = 3'd5;
  localparam logic [2:0] RegRadius      = 3'd6;

  localparam logic [RadW-1:0] RadiusReset = 16'd512;

  // node payload handed from cell to cell
  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic                   keep;
    logic [IdxW-1:0]        node_index;
    logic                   last_node;
  } node_t;

  // result beat
  typedef struct packed {
    logic               in_view;
    logic [HandleW-1:0] node_handle;
    logic               frame_end;
  } result_t;

endpackage

FILE: rtl/sfc_plane_cell.sv
// sfc_plane_cell: one frustum plane test, two register stages (products, then sum/compare).
// Depends on sfc_pkg.
module sfc_plane_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [63:0]    plane,
  input  logic [15:0]    radius,
  input  logic           valid_in,
  input  sfc_pkg::node_t node_in,
  output logic           valid_out,
  output sfc_pkg::node_t node_out
);
  import sfc_pkg::*;

  logic signed [NormW-1:0] nx, ny, nz;
  logic signed [DistW-1:0] dd;
  logic signed [ProdW-1:0] prod_x, prod_y, prod_z;
  logic signed [ProdW-1:0] prod_x_next, prod_y_next, prod_z_next;
  logic signed [SumW-1:0]  dist_sum;
  logic                    a_valid;
  node_t                   a_node;
  logic                    b_valid;
  node_t                   b_node;
  node_t                   b_node_next;

  assign nx = plane[13:0];
  assign ny = plane[27:14];
  assign nz = plane[41:28];
  assign dd = plane[63:42];

  assign prod_x_next = nx * node_in.pos_x;
  assign prod_y_next = ny * node_in.pos_y;
  assign prod_z_next = nz * node_in.pos_z;

  // dist + radius < 0 means the sphere is fully outside
  assign dist_sum = SumW'(prod_x) + SumW'(prod_y) + SumW'(prod_z)
                  + (SumW'(dd) <<< FracShift)
                  + $signed({(SumW - RadW - FracShift)'(0), radius, FracShift'(0)});

  always_comb begin
    b_node_next      = a_node;
    b_node_next.keep = a_node.keep & ~dist_sum[SumW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= valid_in;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
      prod_z <= prod_z_next;
      a_node <= node_in;
      b_node <= b_node_next;
    end
  end

  assign valid_out = b_valid;
  assign node_out  = b_node;

endmodule

FILE: rtl/sfc_out_skid.sv
// sfc_out_skid: output register plus one skid entry for the result stream.
// Depends on sfc_pkg.
module sfc_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sfc_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output sfc_pkg::result_t out_data,
  input  logic             out_ready
);
  import sfc_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid && !skid_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= in_data;
      end
    end else if (skid_valid) begin
      // upstream is held while the skid is full, so in_valid is low here
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      out_data  <= in_data;
    end
  end

endmodule

FILE: rtl/sphere_frustum_cull.sv
// sphere_frustum_cull: top level, config registers, six plane cells in a chain, output skid.
// Depends on sfc_pkg, sfc_plane_cell, sfc_out_skid.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  s_*      in   s_tvalid/s_tready  tdata pos_x,pos_y,pos_z,node_index; tuser; tlast
//  m_*      out  m_tvalid/m_tready  tdata node_handle; tuser in_view; tlast
//  cfg_*    in   cfg_we             cfg_index (reg 0..6), cfg_data (64)
//
// One beat in per cycle while s_tready is high, one result beat out per node. The path
// runs through two register stages per plane cell (products, then sum and compare) in
// each of the six cells, plus the output register. Reset (rst, synchronous) empties the chain and
// loads planes to zero and radius to 2.0. A stalled m side fills the skid entry,
// after which s_tready drops and the whole chain holds until the skid drains.
module sphere_frustum_cull (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // pos_x[23:0], pos_y[47:24], pos_z[71:48], node_index[87:72]
  input  logic [1:0]  s_tuser,   // shown[0], has_mesh[1]
  input  logic        s_tlast,   // last_node
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // node_handle[16:0], zero pad [23:17]
  output logic        m_tuser,   // in_view
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sfc_pkg::*;

  logic [63:0]     planes [PlaneCount];
  logic [RadW-1:0] radius;

  // config writes; index 7 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PlaneCount; i++) planes[i] <= '0;
      radius <= RadiusReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPlaneLeft:   planes[0] <= cfg_data;
        RegPlaneRight:  planes[1] <= cfg_data;
        RegPlaneBottom: planes[2] <= cfg_data;
        RegPlaneTop:    planes[3] <= cfg_data;
        RegPlaneNear:   planes[4] <= cfg_data;
        RegPlaneFar:    planes[5] <= cfg_data;
        RegRadius:      radius    <= cfg_data[RadW-1:0];
        default:        ;
      endcase
    end
  end

  // chain advance: everything moves unless the skid entry is occupied
  logic    en;
  node_t   head;
  logic    chain_valid [PlaneCount+1];
  node_t   chain_node  [PlaneCount+1];
  result_t res;

  always_comb begin
    head.pos_x      = s_tdata[23:0];
    head.pos_y      = s_tdata[47:24];
    head.pos_z      = s_tdata[71:48];
    head.node_index = s_tdata[87:72];
    head.last_node  = s_tlast;
    // hidden or meshless nodes are culled up front; the index check against NodeCountMax passes every 16-bit index
    head.keep       = s_tuser[0] & s_tuser[1]
                    & ({1'b0, s_tdata[87:72]} < NodeCountMax);
  end

  assign s_tready       = en;
  assign chain_valid[0] = s_tvalid;
  assign chain_node[0]  = head;

  for (genvar p = 0; p < PlaneCount; p++) begin : g_cell
    sfc_plane_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .plane     (planes[p]),
      .radius    (radius),
      .valid_in  (chain_valid[p]),
      .node_in   (chain_node[p]),
      .valid_out (chain_valid[p+1]),
      .node_out  (chain_node[p+1])
    );
  end

  always_comb begin
    res.in_view     = chain_node[PlaneCount].keep;
    res.node_handle = chain_node[PlaneCount].keep
                    ? ({1'b0, chain_node[PlaneCount].node_index} + HandleW'(1))
                    : '0;
    res.frame_end   = chain_node[PlaneCount].last_node;
  end

  result_t out_res;

  sfc_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[PlaneCount] & en),
    .in_data   (res),
    .in_ready  (en),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'b0, out_res.node_handle};
  assign m_tuser = out_res.in_view;
  assign m_tlast = out_res.frame_end;

  // a kept node always carries a nonzero handle, a culled one a zero handle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[16:0] != 17'd0)
    else $error("kept node with zero handle");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[16:0] == 17'd0)
    else $error("culled node with nonzero handle");

  // the chain only stalls when a finished result is waiting on the m side
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(m_tready))
    else $error("chain stalled without a waiting result");

  // reset empties the output
  assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

endmodule
